>>> rtl/core/etf_pkg.sv
package etf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int ENTRY_W = 52;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [63:0] ROM_E = 64'd3790295335;

    typedef logic [255:0][15:0] t_rom_tbl;

    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic        [19:0] mag;
    } t_centre;

    // sigmoid((i-128)/8) in Q1.15, built by long division at elaboration
    function automatic t_rom_tbl build_rom();
        t_rom_tbl    tbl;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] s;
        tbl = '0;
        p   = 64'h1_0000_0000;
        for (int k = 0; k <= 128; k++) begin
            d   = 64'h1_0000_0000 + p;
            num = (64'd1 << 47) + (d >> 1);
            rem = '0;
            s   = '0;
            for (int b = 47; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= d) begin
                    rem  = rem - d;
                    s[b] = 1'b1;
                end
            end
            if (k < 128) tbl[128 + k] = s[15:0];
            if (k > 0)   tbl[128 - k] = 16'(17'd32768 - s[16:0]);
            p = (p * ROM_E + 64'h8000_0000) >> 32;
        end
        return tbl;
    endfunction

    localparam t_rom_tbl TANH_ROM = build_rom();

endpackage

>>> rtl/core/etf_ram.sv
module etf_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_addr] <= i_wdata;
        o_rdata <= mem[i_addr];
    end
endmodule

>>> rtl/core/etf_wpipe.sv
module etf_wpipe #(
    parameter int MAX_RADIUS = etf_pkg::DEF_MAX_RADIUS,
    parameter int ACC_W      = 60
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_issue,
    input  logic                    i_clr,
    input  etf_pkg::t_centre        i_ctr,
    input  logic [etf_pkg::ENTRY_W-1:0] i_rdata,
    output logic                    o_busy,
    output logic signed [ACC_W-1:0] o_sx,
    output logic signed [ACC_W-1:0] o_sy,
    output logic                    o_neg
);
    import etf_pkg::*;

    localparam int KW = ACC_W - 16;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: products and magnitude index
    logic signed [15:0] ntx, nty;
    logic signed [20:0] diff;
    logic        [7:0]  idx;
    logic signed [31:0] p1, p2;
    logic signed [31:0] r_p1, r_p2;
    logic signed [15:0] r_ntx2, r_nty2, r_ntx3, r_nty3, r_ntx4, r_nty4;
    logic        [7:0]  r_idx;

    // stage 2: dot and table
    logic signed [32:0] dot;
    logic        [31:0] absdot;
    logic        [31:0] r_abs;
    logic               r_neg3, r_neg4;
    logic        [15:0] r_rom;

    // stage 3: weight
    logic        [47:0] wprod;
    logic        [32:0] r_w;

    // stage 4: signed weight times vector
    logic signed [33:0] sw;
    logic signed [49:0] wx, wy;
    logic signed [49:0] r_wx, r_wy;
    logic signed [33:0] r_sw;

    logic signed [ACC_W-1:0] r_sx, r_sy;
    logic signed [KW-1:0]    r_ks;

    always_comb begin
        ntx  = i_rdata[15:0];
        nty  = i_rdata[31:16];
        p1   = i_ctr.tx * ntx;
        p2   = i_ctr.ty * nty;
        diff = $signed({1'b0, i_rdata[51:32]}) - $signed({1'b0, i_ctr.mag});
        if (diff < -21'sd128)     idx = 8'd0;
        else if (diff > 21'sd127) idx = 8'd255;
        else                      idx = {~diff[7], diff[6:0]};
        dot    = 33'(r_p1) + 33'(r_p2);
        absdot = dot[32] ? 32'(-dot) : dot[31:0];
        wprod  = 48'(r_rom) * 48'(r_abs);
        sw     = r_neg4 ? -$signed({1'b0, r_w}) : $signed({1'b0, r_w});
        wx     = sw * r_ntx4;
        wy     = sw * r_nty4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && (dot != '0);   // zero dot: neighbour dropped
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= p1;
        r_p2   <= p2;
        r_ntx2 <= ntx;
        r_nty2 <= nty;
        r_idx  <= idx;
        r_abs  <= absdot;
        r_neg3 <= dot[32];
        r_rom  <= TANH_ROM[r_idx];
        r_ntx3 <= r_ntx2;
        r_nty3 <= r_nty2;
        r_w    <= wprod[47:15];
        r_neg4 <= r_neg3;
        r_ntx4 <= r_ntx3;
        r_nty4 <= r_nty3;
        r_wx   <= wx;
        r_wy   <= wy;
        r_sw   <= sw;
        if (i_clr) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ks <= '0;
        end else if (r_v5) begin
            r_sx <= r_sx + ACC_W'(r_wx);
            r_sy <= r_sy + ACC_W'(r_wy);
            r_ks <= r_ks + KW'(r_sw);
        end
    end

    assign o_busy = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_sx   = r_sx;
    assign o_sy   = r_sy;
    assign o_neg  = r_ks[KW-1];
endmodule

>>> rtl/core/etf_norm.sv
module etf_norm #(
    parameter int ACC_W = 60
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_sx,
    input  logic signed [ACC_W-1:0] i_sy,
    input  logic                    i_flip,
    output logic                    o_done,
    output logic signed [15:0]      o_qx,
    output logic signed [15:0]      o_qy
);
    import etf_pkg::*;

    typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE} t_nstate;

    t_nstate           r_state;
    logic [ACC_W-1:0]  r_ax, r_ay;
    logic              r_sgx, r_sgy;
    logic [61:0]       r_n, r_res;
    logic [4:0]        r_i;
    logic [30:0]       r_l;
    logic [46:0]       r_remx, r_remy;
    logic [15:0]       r_qx, r_qy;

    logic [ACC_W-1:0]  axy;
    logic [61:0]       sq, trial;
    logic [46:0]       dsub;

    always_comb begin
        axy   = r_ax | r_ay;
        sq    = 62'(r_ax[29:0]) * 62'(r_ax[29:0]) + 62'(r_ay[29:0]) * 62'(r_ay[29:0]);
        trial = r_res + (62'd1 << {r_i, 1'b0});
        dsub  = 47'(r_l) << r_i[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_ax  <= i_sx[ACC_W-1] ? ACC_W'(-i_sx) : i_sx;
                        r_ay  <= i_sy[ACC_W-1] ? ACC_W'(-i_sy) : i_sy;
                        r_sgx <= i_sx[ACC_W-1] ^ i_flip;
                        r_sgy <= i_sy[ACC_W-1] ^ i_flip;
                        r_qx  <= '0;
                        r_qy  <= '0;
                        if (i_sx == '0 && i_sy == '0) r_state <= N_DONE;
                        else                          r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if ((axy >> 30) != '0) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (axy[29] == 1'b0) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end else begin
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_n     <= sq;
                    r_res   <= '0;
                    r_i     <= 5'd30;
                    r_state <= N_SQRT;
                end
                N_SQRT: begin
                    if (r_n >= trial) begin
                        r_n   <= r_n - trial;
                        r_res <= (r_res >> 1) + (62'd1 << {r_i, 1'b0});
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    if (r_i == '0) r_state <= N_DIV;
                    else           r_i <= r_i - 5'd1;
                end
                N_DIV: begin
                    if (r_i == 5'd0 && r_state == N_DIV && r_l == '0) begin
                        // first cycle: square root settled, set up the dividends
                        r_l    <= r_res[30:0];
                        r_remx <= (47'(r_ax[29:0]) << 14) + 47'(r_res[30:1]);
                        r_remy <= (47'(r_ay[29:0]) << 14) + 47'(r_res[30:1]);
                        r_i    <= 5'd15;
                    end else begin
                        if (r_remx >= dsub) begin
                            r_remx          <= r_remx - dsub;
                            r_qx[r_i[3:0]]  <= 1'b1;
                        end
                        if (r_remy >= dsub) begin
                            r_remy          <= r_remy - dsub;
                            r_qy[r_i[3:0]]  <= 1'b1;
                        end
                        if (r_i == '0) r_state <= N_DONE;
                        else           r_i <= r_i - 5'd1;
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
            if (r_state == N_IDLE || r_state == N_DONE) r_l <= '0;
        end
    end

    assign o_done = (r_state == N_DONE);
    assign o_qx   = r_sgx ? 16'(-r_qx) : r_qx;
    assign o_qy   = r_sgy ? 16'(-r_qy) : r_qy;
endmodule

>>> rtl/core/edge_tangent_flow_refine.sv
// Write word: written to the store at the edge that accepts it, if inside the store; no result.
// Compute word: centre read, then a scan of the (2R-1)^2 window positions (one store read
//   per cycle, R = effective radius), then the weight pipeline drains, then normalize
//   (shift search, square root 31 steps, divide 16 steps).
// One word in flight; the next is accepted once the result sits in the output reg.
// Reset: config returns to radius 5, frame 256x256; the store is not cleared.
module edge_tangent_flow_refine #(
    parameter int MAX_WIDTH  = etf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = etf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = etf_pkg::DEF_MAX_RADIUS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [7:0]         i_pixel_row,
    input  logic [7:0]         i_pixel_col,
    input  logic signed [15:0] i_tangent_x,
    input  logic signed [15:0] i_tangent_y,
    input  logic [19:0]        i_grad_mag,
    // result words
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_refined_x,
    output logic signed [15:0] o_refined_y,
    output logic [7:0]         o_result_row,
    output logic [7:0]         o_result_col,
    // config
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data
);
    import etf_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int RW    = $clog2(MAX_RADIUS) + 2;     // signed window offset
    localparam int DW    = 2 * RW + 1;                 // squared distance
    localparam int PW    = 14;                         // signed neighbour position
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int ACC_W = 50 + $clog2((2 * MAX_RADIUS - 1) * (2 * MAX_RADIUS - 1) + 1);

    typedef enum logic [2:0] {S_IDLE, S_CTR, S_SCAN, S_DRAIN, S_NORM, S_FIN} t_state;

    t_state r_state;

    logic [3:0] r_rad;
    logic [8:0] r_fw, r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= 4'd5;
            r_fw  <= 9'd256;
            r_fh  <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_rad <= i_cfg_data[3:0];
                CFG_WIDTH:  r_fw  <= i_cfg_data;
                CFG_HEIGHT: r_fh  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // effective limits: saturate at the build-time maxima
    logic signed [RW-1:0] rad_eff, lim, lo;
    logic [WB-1:0]        fw_eff;
    logic [HB-1:0]        fh_eff;

    always_comb begin
        rad_eff = (r_rad > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_rad);
        fw_eff  = (r_fw > MAX_WIDTH)   ? WB'(MAX_WIDTH)  : WB'(r_fw);
        fh_eff  = (r_fh > MAX_HEIGHT)  ? HB'(MAX_HEIGHT) : HB'(r_fh);
        lim     = RW'(rad_eff - RW'(1));
        lo      = RW'(RW'(1) - rad_eff);
    end

    logic [7:0]           r_row, r_col;
    logic signed [RW-1:0] r_dr, r_dc;
    logic                 r_cout;
    t_centre              r_ctr;

    // window position for the current scan step
    logic signed [PW-1:0] nr, nc;
    logic signed [DW-1:0] d2, rr;
    logic                 hit;

    always_comb begin
        nr  = $signed({{(PW-8){1'b0}}, r_row}) + PW'(r_dr);
        nc  = $signed({{(PW-8){1'b0}}, r_col}) + PW'(r_dc);
        d2  = DW'(r_dr) * DW'(r_dr) + DW'(r_dc) * DW'(r_dc);
        rr  = DW'(rad_eff) * DW'(rad_eff);
        hit = (r_state == S_SCAN) && (d2 < rr) && (nr >= 0) && (nc >= 0)
              && (nr < $signed(PW'(fh_eff))) && (nc < $signed(PW'(fw_eff)));
    end

    // store port: idle serves the write / centre read, scan serves neighbours
    logic                 acc_in;
    logic                 in_store;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [ENTRY_W-1:0]   ram_rdata;

    always_comb begin
        acc_in   = i_valid && (r_state == S_IDLE);
        in_store = (i_pixel_row < MAX_HEIGHT) && (i_pixel_col < MAX_WIDTH);
        ram_we   = acc_in && (i_func == FUNC_WRITE) && in_store;
        if (r_state == S_SCAN)
            ram_addr = AW'(AW'($unsigned(nr)) * MAX_WIDTH + AW'($unsigned(nc)));
        else
            ram_addr = AW'(AW'(i_pixel_row) * MAX_WIDTH + AW'(i_pixel_col));
    end

    etf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_grad_mag, i_tangent_y, i_tangent_x}),
        .o_rdata (ram_rdata)
    );

    logic                    wp_busy, wp_neg;
    logic signed [ACC_W-1:0] wp_sx, wp_sy;

    etf_wpipe #(
        .MAX_RADIUS (MAX_RADIUS),
        .ACC_W      (ACC_W)
    ) u_wpipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (hit),
        .i_clr   (r_state == S_CTR),
        .i_ctr   (r_ctr),
        .i_rdata (ram_rdata),
        .o_busy  (wp_busy),
        .o_sx    (wp_sx),
        .o_sy    (wp_sy),
        .o_neg   (wp_neg)
    );

    logic               nm_start, nm_done;
    logic signed [15:0] nm_qx, nm_qy;

    assign nm_start = (r_state == S_DRAIN) && !wp_busy;

    etf_norm #(
        .ACC_W (ACC_W)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nm_start),
        .i_sx    (wp_sx),
        .i_sy    (wp_sy),
        .i_flip  (wp_neg),
        .o_done  (nm_done),
        .o_qx    (nm_qx),
        .o_qy    (nm_qy)
    );

    logic r_ovalid;
    logic out_free;

    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc_in && i_func == FUNC_COMPUTE) begin
                        r_row   <= i_pixel_row;
                        r_col   <= i_pixel_col;
                        r_cout  <= !in_store;
                        r_state <= S_CTR;
                    end
                end
                S_CTR: begin
                    // centre word arrives; outside the store it reads as zero
                    r_ctr.tx  <= r_cout ? '0 : ram_rdata[15:0];
                    r_ctr.ty  <= r_cout ? '0 : ram_rdata[31:16];
                    r_ctr.mag <= r_cout ? '0 : ram_rdata[51:32];
                    r_dr      <= lo;
                    r_dc      <= lo;
                    if (rad_eff == '0) r_state <= S_DRAIN;
                    else               r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_dc == lim) begin
                        r_dc <= lo;
                        if (r_dr == lim) r_state <= S_DRAIN;
                        else             r_dr <= r_dr + RW'(1);
                    end else begin
                        r_dc <= r_dc + RW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!wp_busy) r_state <= S_NORM;
                end
                S_NORM: begin
                    if (nm_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        o_refined_x  <= nm_qx;
                        o_refined_y  <= nm_qy;
                        o_result_row <= r_row;
                        o_result_col <= r_col;
                        r_ovalid     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
endmodule
